### hw/rtl/bmcs_pkg.sv
// ----------------------------------------------------------------------------
// bmcs_pkg
// Shared types and constants of the byte memory processor step block.
// ----------------------------------------------------------------------------
package bmcs_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegAw    = 4;
  localparam int unsigned XLen     = 32;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EXEC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [4:0] {
    OP_HLT   = 5'd0,
    OP_NOP   = 5'd1,
    OP_NOT   = 5'd2,
    OP_MOVR  = 5'd3,
    OP_CMP   = 5'd4,
    OP_LDBO  = 5'd5,
    OP_STBO  = 5'd6,
    OP_ADD   = 5'd7,
    OP_SUB   = 5'd8,
    OP_MUL   = 5'd9,
    OP_DIV   = 5'd10,
    OP_AND   = 5'd11,
    OP_OR    = 5'd12,
    OP_XOR   = 5'd13,
    OP_LD    = 5'd14,
    OP_ST    = 5'd15,
    OP_MOVIL = 5'd16,
    OP_MOVIH = 5'd17,
    OP_ADDI  = 5'd18,
    OP_SUBI  = 5'd19,
    OP_MULTI = 5'd20,
    OP_DIVI  = 5'd21,
    OP_LSH   = 5'd22,
    OP_RSH   = 5'd23,
    OP_JE    = 5'd24,
    OP_JNE   = 5'd25,
    OP_JL    = 5'd26,
    OP_JLE   = 5'd27,
    OP_JG    = 5'd28,
    OP_JGE   = 5'd29,
    OP_JMP   = 5'd30
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BYTE,
    ST_BWAIT,
    ST_FETCH,
    ST_RREAD,
    ST_EXEC,
    ST_LOAD,
    ST_STORE,
    ST_MULDIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic            start;
    logic            is_div;
    logic [XLen-1:0] x;
    logic [XLen-1:0] y;
  } md_req_t;

endpackage

### hw/rtl/byte_memory_cpu_step.sv
// ----------------------------------------------------------------------------
// byte_memory_cpu_step
// Byte memory processor that takes one word per step: a byte write, a byte
// read, or the fetch and execution of one big-endian instruction.
//
// Input channel: kind, byte address and byte value, with valid and stall.
// Output channel: one result word per input word, with valid and stall.
// One word is worked on at a time; the input stalls until the previous step
// has moved into the output register, which then waits for the receiver.
// States per word, accept to output register: byte write BYTE, FIN;
//   byte read BYTE, BWAIT, FIN; kind 3 or execute after halt FIN; execute
//   FETCH, RREAD, EXEC, then LOAD, STORE or MULDIV (mul/div/multi/divi), FIN.
// The instruction fetch and loads go one byte a cycle through the single read
// port of the byte memory, stores through its write port; register operands
// are read one a cycle from the register file; mul/div iterate one bit a cycle.
// After reset a clearing pass zeroes the memory and the register file, during
// which the input stalls.
// A stalled output holds its word; the next step finishes and waits.
// MEM_BYTES must be a power of two (not checked here); addresses wrap at it.
// ----------------------------------------------------------------------------
module byte_memory_cpu_step #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  byte_address_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  program_counter_o,
  output logic        halted_o,
  output logic [4:0]  opcode_o,
  output logic        reg_written_o,
  output logic [3:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        flag_equal_o,
  output logic        flag_less_o,
  output logic        flag_greater_o,
  output logic [7:0]  read_byte_o
);
  import bmcs_pkg::*;

  localparam int unsigned Aw = $clog2(MEM_BYTES);

  state_e state_q, state_d;

  logic [Aw-1:0]    clr_q, clr_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       baddr_q, baddr_d;
  logic [7:0]       bval_q, bval_d;
  logic [31:0]      word_q, word_d;
  logic [XLen-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [Aw-1:0]    addr_q, addr_d;
  logic [Aw-1:0]    pc_q, pc_d;
  logic             eq_q, eq_d, lt_q, lt_d, gt_q, gt_d, halt_q, halt_d;
  logic [4:0]       rop_q, rop_d;
  logic             rwr_q, rwr_d;
  logic [RegAw-1:0] ridx_q, ridx_d;
  logic [XLen-1:0]  rval_q, rval_d;
  logic [7:0]       rbyte_q, rbyte_d;

  logic             ov_q, ov_d;
  logic [7:0]       opc_q, opc_d;
  logic             oh_q, oh_d;
  logic [4:0]       oop_q, oop_d;
  logic             owr_q, owr_d;
  logic [RegAw-1:0] oidx_q, oidx_d;
  logic [XLen-1:0]  oval_q, oval_d;
  logic             oeq_q, oeq_d, olt_q, olt_d, ogt_q, ogt_d;
  logic [7:0]       orb_q, orb_d;

  logic             mem_we;
  logic [Aw-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             rf_we;
  logic [RegAw-1:0] rf_waddr, rf_raddr;
  logic [XLen-1:0]  rf_wdata, rf_rdata;

  md_req_t          md_req;
  logic             md_done;
  logic [XLen-1:0]  md_result;

  logic             in_acc, fin_go;
  logic [4:0]       op;
  logic [RegAw-1:0] ra, rb, rc;
  logic [22:0]      imm;
  logic             is_load, is_store, is_md;

  assign op  = word_q[31:27];
  assign ra  = word_q[26:23];
  assign rb  = word_q[22:19];
  assign rc  = word_q[18:15];
  assign imm = word_q[22:0];

  assign is_load  = (op == OP_LDBO) || (op == OP_LD);
  assign is_store = (op == OP_STBO) || (op == OP_ST);
  assign is_md    = (op == OP_MUL) || (op == OP_DIV) || (op == OP_MULTI) || (op == OP_DIVI);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fin_go     = !ov_q || !out_stall_i;

  bmcs_ram #(.Width(8), .Depth(MEM_BYTES), .Aw(Aw)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bmcs_ram #(.Width(XLen), .Depth(NumRegs), .Aw(RegAw)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  bmcs_muldiv u_md (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .done_o   (md_done),
    .result_o (md_result)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_WRITE || kind_i == KIND_READ) begin
            state_d = ST_BYTE;
          end else if (kind_i == KIND_EXEC && !halt_q) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_BYTE:   state_d = (kind_q == KIND_READ) ? ST_BWAIT : ST_FIN;
      ST_BWAIT:  state_d = ST_FIN;
      ST_FETCH:  if (cnt_q == 3'd4) state_d = ST_RREAD;
      ST_RREAD:  if (cnt_q == 3'd3) state_d = ST_EXEC;
      ST_EXEC: begin
        if (is_load) begin
          state_d = ST_LOAD;
        end else if (is_store) begin
          state_d = ST_STORE;
        end else if (is_md) begin
          state_d = ST_MULDIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_LOAD:   if (cnt_q == 3'd4) state_d = ST_FIN;
      ST_STORE:  if (cnt_q == 3'd3) state_d = ST_FIN;
      ST_MULDIV: if (md_done) state_d = ST_FIN;
      ST_FIN:    if (fin_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    baddr_d = baddr_q;
    bval_d  = bval_q;
    word_d  = word_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    addr_d  = addr_q;
    pc_d    = pc_q;
    eq_d    = eq_q;
    lt_d    = lt_q;
    gt_d    = gt_q;
    halt_d  = halt_q;
    rop_d   = rop_q;
    rwr_d   = rwr_q;
    ridx_d  = ridx_q;
    rval_d  = rval_q;
    rbyte_d = rbyte_q;
    ov_d    = ov_q;
    opc_d   = opc_q;
    oh_d    = oh_q;
    oop_d   = oop_q;
    owr_d   = owr_q;
    oidx_d  = oidx_q;
    oval_d  = oval_q;
    oeq_d   = oeq_q;
    olt_d   = olt_q;
    ogt_d   = ogt_q;
    orb_d   = orb_q;

    mem_we    = 1'b0;
    mem_waddr = addr_q + Aw'(cnt_q[1:0]);
    mem_wdata = '0;
    mem_raddr = pc_q + Aw'(cnt_q[1:0]);
    rf_we     = 1'b0;
    rf_waddr  = ridx_q;
    rf_wdata  = rval_q;
    rf_raddr  = ra;
    md_req    = '0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q[Aw-1:RegAw] == '0) begin
          rf_we    = 1'b1;
          rf_waddr = clr_q[RegAw-1:0];
          rf_wdata = '0;
        end
        clr_d = clr_q + Aw'(1);
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          kind_d  = kind_i;
          baddr_d = byte_address_i;
          bval_d  = byte_value_i;
          rop_d   = '0;
          rwr_d   = 1'b0;
          ridx_d  = '0;
          rval_d  = '0;
          rbyte_d = '0;
        end
      end
      ST_BYTE: begin
        mem_we    = (kind_q == KIND_WRITE);
        mem_waddr = Aw'(baddr_q);
        mem_wdata = bval_q;
        mem_raddr = Aw'(baddr_q);
      end
      ST_BWAIT: rbyte_d = mem_rdata;
      ST_FETCH: begin
        if (cnt_q != 3'd0) begin
          word_d = {word_q[23:0], mem_rdata};
        end
        cnt_d = (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
      end
      ST_RREAD: begin
        case (cnt_q)
          3'd0:    rf_raddr = ra;
          3'd1:    rf_raddr = rb;
          default: rf_raddr = rc;
        endcase
        case (cnt_q)
          3'd1:    a_d = rf_rdata;
          3'd2:    b_d = rf_rdata;
          3'd3:    c_d = rf_rdata;
          default: a_d = a_q;
        endcase
        cnt_d = (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
      end
      ST_EXEC: begin
        rop_d  = op;
        ridx_d = ra;
        pc_d   = pc_q + Aw'(4);
        if (op == OP_LDBO || op == OP_STBO) begin
          addr_d = Aw'(b_q) + Aw'(word_q[18:0]);
        end else begin
          addr_d = Aw'(word_q[7:0]);
        end
        md_req.start  = is_md;
        md_req.is_div = (op == OP_DIV) || (op == OP_DIVI);
        md_req.x      = ((op == OP_MUL) || (op == OP_DIV)) ? b_q : a_q;
        md_req.y      = ((op == OP_MUL) || (op == OP_DIV)) ? c_q : XLen'(imm);
        rwr_d = is_load || is_md;
        case (op)
          OP_HLT:   halt_d = 1'b1;
          OP_NOT:   begin rwr_d = 1'b1; rval_d = XLen'(a_q == '0); end
          OP_MOVR:  begin rwr_d = 1'b1; rval_d = b_q; end
          OP_CMP: begin
            eq_d = (a_q == b_q);
            lt_d = (a_q < b_q);
            gt_d = (a_q > b_q);
          end
          OP_ADD:   begin rwr_d = 1'b1; rval_d = b_q + c_q; end
          OP_SUB:   begin rwr_d = 1'b1; rval_d = b_q - c_q; end
          OP_AND:   begin rwr_d = 1'b1; ridx_d = rc; rval_d = b_q & a_q; end
          OP_OR:    begin rwr_d = 1'b1; ridx_d = rc; rval_d = b_q | a_q; end
          OP_XOR:   begin rwr_d = 1'b1; ridx_d = rc; rval_d = b_q ^ a_q; end
          OP_MOVIL: begin rwr_d = 1'b1; rval_d = {16'h0000, imm[15:0]}; end
          OP_MOVIH: begin rwr_d = 1'b1; rval_d = {imm[15:0], a_q[15:0]}; end
          OP_ADDI:  begin rwr_d = 1'b1; rval_d = a_q + XLen'(imm); end
          OP_SUBI:  begin rwr_d = 1'b1; rval_d = a_q - XLen'(imm); end
          OP_LSH: begin
            rwr_d  = 1'b1;
            rval_d = (imm[22:5] == '0) ? (a_q << imm[4:0]) : '0;
          end
          OP_RSH: begin
            rwr_d  = 1'b1;
            rval_d = (imm[22:5] == '0) ? (a_q >> imm[4:0]) : '0;
          end
          OP_JE:    if (eq_q) pc_d = Aw'(imm);
          OP_JNE:   if (!eq_q) pc_d = Aw'(imm);
          OP_JL:    if (lt_q) pc_d = Aw'(imm);
          OP_JLE:   if (eq_q || lt_q) pc_d = Aw'(imm);
          OP_JG:    if (gt_q) pc_d = Aw'(imm);
          OP_JGE:   if (eq_q || gt_q) pc_d = Aw'(imm);
          OP_JMP:   pc_d = Aw'(imm);
          default:  rval_d = rval_q;
        endcase
      end
      ST_LOAD: begin
        mem_raddr = addr_q + Aw'(cnt_q[1:0]);
        if (cnt_q != 3'd0) begin
          rval_d = {rval_q[23:0], mem_rdata};
        end
        cnt_d = (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
      end
      ST_STORE: begin
        mem_we = 1'b1;
        case (cnt_q[1:0])
          2'd0:    mem_wdata = a_q[31:24];
          2'd1:    mem_wdata = a_q[23:16];
          2'd2:    mem_wdata = a_q[15:8];
          default: mem_wdata = a_q[7:0];
        endcase
        cnt_d = (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
      end
      ST_MULDIV: if (md_done) rval_d = md_result;
      ST_FIN: begin
        if (fin_go) begin
          rf_we  = rwr_q;
          ov_d   = 1'b1;
          opc_d  = 8'(pc_q);
          oh_d   = halt_q;
          oop_d  = rop_q;
          owr_d  = rwr_q;
          oidx_d = rwr_q ? ridx_q : '0;
          oval_d = rwr_q ? rval_q : '0;
          oeq_d  = eq_q;
          olt_d  = lt_q;
          ogt_d  = gt_q;
          orb_d  = rbyte_q;
        end
      end
      default: cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      pc_q    <= '0;
      eq_q    <= 1'b0;
      lt_q    <= 1'b0;
      gt_q    <= 1'b0;
      halt_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      eq_q    <= eq_d;
      lt_q    <= lt_d;
      gt_q    <= gt_d;
      halt_q  <= halt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    baddr_q <= baddr_d;
    bval_q  <= bval_d;
    word_q  <= word_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    addr_q  <= addr_d;
    rop_q   <= rop_d;
    rwr_q   <= rwr_d;
    ridx_q  <= ridx_d;
    rval_q  <= rval_d;
    rbyte_q <= rbyte_d;
    opc_q   <= opc_d;
    oh_q    <= oh_d;
    oop_q   <= oop_d;
    owr_q   <= owr_d;
    oidx_q  <= oidx_d;
    oval_q  <= oval_d;
    oeq_q   <= oeq_d;
    olt_q   <= olt_d;
    ogt_q   <= ogt_d;
    orb_q   <= orb_d;
  end

  assign out_valid_o       = ov_q;
  assign program_counter_o = opc_q;
  assign halted_o          = oh_q;
  assign opcode_o          = oop_q;
  assign reg_written_o     = owr_q;
  assign reg_index_o       = oidx_q;
  assign reg_value_o       = oval_q;
  assign flag_equal_o      = oeq_q;
  assign flag_less_o       = olt_q;
  assign flag_greater_o    = ogt_q;
  assign read_byte_o       = orb_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(halt_q))
    else $error("halt flag cleared without reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_o)
    else $error("result word during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == ST_FIN)
    else $error("result word loaded outside finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> state_q == ST_MULDIV)
    else $error("mul/div done while not waiting for it");

endmodule

### hw/rtl/bmcs_ram.sv
// ----------------------------------------------------------------------------
// bmcs_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bmcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bmcs_muldiv.sv
// ----------------------------------------------------------------------------
// bmcs_muldiv
// Iterative 32-bit multiplier (low word) and restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module bmcs_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmcs_pkg::md_req_t     req_i,
  output logic                  done_o,
  output logic [bmcs_pkg::XLen-1:0] result_o
);
  import bmcs_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            div_q, div_d;
  logic [XLen-1:0] x_q, x_d;
  logic [XLen-1:0] y_q, y_d;
  logic [XLen-1:0] acc_q, acc_d;
  logic [XLen:0]   rem_q, rem_d;
  logic [XLen:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[XLen-1:0], x_q[XLen-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.is_div;
      x_d    = req_i.x;
      y_d    = req_i.y;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (div_q) begin
        if (rem_sh >= {1'b0, y_q}) begin
          rem_d = rem_sh - {1'b0, y_q};
          x_d   = {x_q[XLen-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          x_d   = {x_q[XLen-2:0], 1'b0};
        end
      end else begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = {x_q[XLen-2:0], 1'b0};
        y_d = {1'b0, y_q[XLen-1:1]};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? x_q : acc_q;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_memory_cpu_step: a predictor tracks the
// processor state, programs are written into memory and stepped, and every
// result word is checked in full; some phases add random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bmcs_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] value;
  } step_t;

  typedef struct packed {
    logic [7:0]  pc;
    logic        halted;
    logic [4:0]  opcode;
    logic        wr;
    logic [3:0]  idx;
    logic [31:0] val;
    logic        eq;
    logic        lt;
    logic        gt;
    logic [7:0]  rbyte;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [7:0]  byte_address_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  status_t     got;

  byte_memory_cpu_step u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .byte_address_i,
    .byte_value_i, .out_valid_o, .out_stall_i,
    .program_counter_o(got.pc), .halted_o(got.halted), .opcode_o(got.opcode),
    .reg_written_o(got.wr), .reg_index_o(got.idx), .reg_value_o(got.val),
    .flag_equal_o(got.eq), .flag_less_o(got.lt), .flag_greater_o(got.gt),
    .read_byte_o(got.rbyte)
  );

  always #2 clk_i = ~clk_i;

  logic [31:0] cpu_regs [16];
  logic [7:0]  cpu_mem [256];
  logic [7:0]  cpu_pc;
  logic        cpu_eq, cpu_lt, cpu_gt, cpu_halt;

  step_t   pending_steps[$];
  status_t expected_status[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      long_hold = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_cycles = 0;
  int      mismatches = 0;

  function automatic logic [31:0] mem_word(input logic [7:0] a);
    return {cpu_mem[a], cpu_mem[8'(a + 1)], cpu_mem[8'(a + 2)], cpu_mem[8'(a + 3)]};
  endfunction

  function automatic status_t cpu_step(input step_t s);
    status_t r;
    logic [31:0] w, a, b, c, imm, v;
    logic [7:0] ea;
    op_e op;
    logic jmp, take;
    r = '0;
    if (s.kind == KIND_WRITE) begin
      cpu_mem[s.addr] = s.value;
    end else if (s.kind == KIND_READ) begin
      r.rbyte = cpu_mem[s.addr];
    end else if (s.kind == KIND_EXEC && !cpu_halt) begin
      w = mem_word(cpu_pc);
      op = op_e'(w[31:27]);
      a = cpu_regs[w[26:23]];
      b = cpu_regs[w[22:19]];
      c = cpu_regs[w[18:15]];
      imm = {9'd0, w[22:0]};
      r.opcode = w[31:27];
      r.idx = w[26:23];
      v = '0;
      jmp = 1'b0;
      take = 1'b0;
      ea = 8'(b + {13'd0, w[18:0]});
      case (op)
        OP_HLT: cpu_halt = 1'b1;
        OP_NOT: begin r.wr = 1; v = (a == 0) ? 32'd1 : 32'd0; end
        OP_MOVR: begin r.wr = 1; v = b; end
        OP_CMP: begin cpu_eq = (a == b); cpu_lt = (a < b); cpu_gt = (a > b); end
        OP_LDBO: begin r.wr = 1; v = mem_word(ea); end
        OP_STBO: for (int i = 0; i < 4; i++) cpu_mem[8'(ea + i)] = a[31-8*i -: 8];
        OP_ADD: begin r.wr = 1; v = b + c; end
        OP_SUB: begin r.wr = 1; v = b - c; end
        OP_MUL: begin r.wr = 1; v = b * c; end
        OP_DIV: begin r.wr = 1; v = (c == 0) ? '1 : b / c; end
        OP_AND: begin r.wr = 1; r.idx = w[18:15]; v = b & a; end
        OP_OR: begin r.wr = 1; r.idx = w[18:15]; v = b | a; end
        OP_XOR: begin r.wr = 1; r.idx = w[18:15]; v = b ^ a; end
        OP_LD: begin r.wr = 1; v = mem_word(w[7:0]); end
        OP_ST: for (int i = 0; i < 4; i++) cpu_mem[8'(w[7:0] + i)] = a[31-8*i -: 8];
        OP_MOVIL: begin r.wr = 1; v = {16'd0, w[15:0]}; end
        OP_MOVIH: begin r.wr = 1; v = {w[15:0], a[15:0]}; end
        OP_ADDI: begin r.wr = 1; v = a + imm; end
        OP_SUBI: begin r.wr = 1; v = a - imm; end
        OP_MULTI: begin r.wr = 1; v = a * imm; end
        OP_DIVI: begin r.wr = 1; v = (imm == 0) ? '1 : a / imm; end
        OP_LSH: begin r.wr = 1; v = (imm < 32) ? a << imm[4:0] : '0; end
        OP_RSH: begin r.wr = 1; v = (imm < 32) ? a >> imm[4:0] : '0; end
        OP_JE: begin jmp = 1; take = cpu_eq; end
        OP_JNE: begin jmp = 1; take = !cpu_eq; end
        OP_JL: begin jmp = 1; take = cpu_lt; end
        OP_JLE: begin jmp = 1; take = cpu_eq | cpu_lt; end
        OP_JG: begin jmp = 1; take = cpu_gt; end
        OP_JGE: begin jmp = 1; take = cpu_eq | cpu_gt; end
        OP_JMP: begin jmp = 1; take = 1; end
        default: ;
      endcase
      if (op == OP_HLT) r.opcode = '0;
      if (r.wr) cpu_regs[r.idx] = v;
      else r.idx = '0;
      r.val = v;
      cpu_pc = (jmp && take) ? w[7:0] : cpu_pc + 8'd4;
    end
    r.pc = cpu_pc;
    r.halted = cpu_halt;
    r.eq = cpu_eq;
    r.lt = cpu_lt;
    r.gt = cpu_gt;
    return r;
  endfunction

  task automatic push_step(input logic [1:0] k, input logic [7:0] a, input logic [7:0] v);
    pending_steps.push_back('{k, a, v});
  endtask

  task automatic put_instr(input logic [7:0] a, input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_step(KIND_WRITE, 8'(a + i), w[31-8*i -: 8]);
  endtask

  function automatic logic [31:0] rand_instr(input bit allow_halt);
    logic [31:0] w;
    logic [4:0] op;
    w = $urandom;
    op = 5'($urandom_range(allow_halt ? 0 : 1, 31));
    w[31:27] = op;
    case ($urandom_range(0, 5))
      0: w[22:0] = 23'($urandom_range(0, 40));
      1: w[22:0] = 23'h7FFFFF;
      2: w[22:0] = 23'($urandom_range(0, 255));
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_drain();
    while (pending_steps.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!(in_valid_i && in_stall_o)) begin
      if (pending_steps.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        step_t s;
        s = pending_steps.pop_front();
        expected_status.push_back(cpu_step(s));
        in_valid_i <= 1'b1;
        kind_i <= s.kind;
        byte_address_i <= s.addr;
        byte_value_i <= s.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h", got);
      end else begin
        status_t e;
        e = expected_status.pop_front();
        if (e !== got) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p actual %p", e, got);
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (long_hold && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_cycles <= 399;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) cpu_regs[i] = '0;
    for (int i = 0; i < 256; i++) cpu_mem[i] = '0;
    cpu_pc = '0;
    {cpu_eq, cpu_lt, cpu_gt, cpu_halt} = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: byte extremes, kind 3, a short program, halt
    push_step(KIND_WRITE, 8'hFF, 8'hFF);
    push_step(KIND_READ, 8'hFF, 8'h00);
    push_step(KIND_READ, 8'h00, 8'hAA);
    push_step(2'd3, 8'h55, 8'h55);
    put_instr(8'd0, {OP_MOVIL, 4'd1, 7'd0, 16'hFFFF});
    put_instr(8'd4, {OP_DIVI, 4'd1, 23'd0});
    put_instr(8'd8, {OP_LSH, 4'd1, 23'd32});
    put_instr(8'd12, {OP_DIV, 4'd2, 4'd3, 4'd0, 15'd0});
    put_instr(8'd16, {OP_CMP, 4'd1, 4'd2, 19'd0});
    put_instr(8'd20, {OP_JE, 4'd0, 23'd252});
    for (int i = 0; i < 7; i++) push_step(KIND_EXEC, 8'd0, 8'd0);
    wait_drain();
    put_instr(8'd252, {OP_HLT, 27'd0});
    push_step(KIND_EXEC, 8'd0, 8'd0);
    push_step(KIND_EXEC, 8'd0, 8'd0);
    push_step(KIND_READ, 8'd252, 8'd0);
    wait_drain();

    // random programs; no reset comes between phases, so the halt from the directed test stays
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1'b1; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        logic [7:0] start;
        start = cpu_pc;
        for (int i = 0; i < 16; i++)
          put_instr(8'(start + 4 * i), rand_instr(i == 15 && ph == 4 && blk == 2));
        for (int i = 0; i < 40; i++) begin
          case ($urandom_range(0, 9))
            0: push_step(KIND_WRITE, 8'($urandom), 8'($urandom));
            1: push_step(KIND_READ, 8'($urandom), 8'($urandom));
            2: push_step(2'd3, 8'($urandom), 8'($urandom));
            default: push_step(KIND_EXEC, 8'($urandom), 8'($urandom));
          endcase
        end
        wait_drain();
      end
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("byte_memory_cpu_step test passed");
    end else begin
      $display("byte_memory_cpu_step test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("byte_memory_cpu_step test failed");
    $finish;
  end

endmodule
